// ===== sv/oal_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered array list package
// Field widths, command and status codes, transaction types and the control
// structures shared by the list cells and the top level.
// ----------------------------------------------------------------------------
package oal_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int CMD_W         = 3;
	localparam int POS_W         = 7;
	localparam int DATA_W        = 32;
	localparam int STATUS_W      = 3;
	localparam int FOUND_W       = 6;
	localparam int ITEM_CNT_W    = 7;
	localparam int CAP_W         = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_EDIT   = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_GET    = 3'd4,
		CMD_FIND   = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADIDX   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CHECK,
		FSM_SCAN,
		FSM_FINISH
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SHIFT_UP,
		CELL_SHIFT_DN
	} cell_op_t;

	typedef struct packed {
		cmd_t                      command;
		logic [POS_W-1:0]          position;
		logic signed [DATA_W-1:0]  value_in;
	} in_item_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  value_out;
		logic [FOUND_W-1:0]        found_index;
		logic [ITEM_CNT_W-1:0]     item_count;
		logic                      full_flag;
		logic                      empty_flag;
	} out_item_t;

	typedef struct packed {
		cell_op_t op;
		logic     find;
	} cell_ctl_t;

	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [DATA_W-1:0] data;
	} probe_t;

endpackage

// ===== sv/oal_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered array list cell
// Holds one list entry, loads or shifts it from a neighbor on edits, and
// passes a registered search probe on to the next cell.
// ----------------------------------------------------------------------------
module oal_cell #(
	parameter int CMP_W = 7,
	parameter int IDX_W = 6,
	parameter int IDX   = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  oal_pkg::cell_ctl_t            ctl,
	input  logic [CMP_W-1:0]              target,
	input  logic [CMP_W-1:0]              count,
	input  logic [oal_pkg::DATA_W-1:0]    value,
	input  logic [oal_pkg::DATA_W-1:0]    left_data,
	input  logic [oal_pkg::DATA_W-1:0]    right_data,
	output logic [oal_pkg::DATA_W-1:0]    data,
	input  oal_pkg::probe_t               probe_in,
	input  logic [IDX_W-1:0]              pidx_in,
	output oal_pkg::probe_t               probe_out,
	output logic [IDX_W-1:0]              pidx_out
);
	import oal_pkg::*;

	localparam logic [CMP_W-1:0] MY_POS = CMP_W'(IDX);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [DATA_W-1:0] data_q;
	logic              pvalid_q;
	logic              phit_q;
	logic [DATA_W-1:0] pdata_q;
	logic [IDX_W-1:0]  pidx_q;
	logic              match;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_LOAD: begin
				if (MY_POS == target) begin
					data_q <= value;
				end
			end
			CELL_SHIFT_UP: begin
				if (MY_POS == target) begin
					data_q <= value;
				end else if (MY_POS > target) begin
					data_q <= left_data;
				end
			end
			CELL_SHIFT_DN: begin
				if (MY_POS >= target) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	always_comb begin
		match = probe_in.valid && !probe_in.hit && (MY_POS < count) &&
			(ctl.find ? (data_q == value) : (MY_POS == target));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= 1'b0;
			phit_q   <= 1'b0;
		end else begin
			pvalid_q <= probe_in.valid;
			phit_q   <= probe_in.hit | match;
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			pdata_q <= data_q;
			pidx_q  <= MY_IDX;
		end else begin
			pdata_q <= probe_in.data;
			pidx_q  <= pidx_in;
		end
	end

	assign data            = data_q;
	assign probe_out.valid = pvalid_q;
	assign probe_out.hit   = phit_q;
	assign probe_out.data  = pdata_q;
	assign pidx_out        = pidx_q;

endmodule

// ===== sv/ordered_array_list.sv =====
// ----------------------------------------------------------------------------
// Ordered array list
// An ordered list of signed 32-bit entries held in a row of cells, with
// append, insert, edit, delete, get and find commands.
// ----------------------------------------------------------------------------
// Commands arrive on the in channel (in_valid/in_ready) and every command
// produces exactly one result transaction on the out channel
// (out_valid/out_ready). The block works on one command at a time.
// Append, insert, edit and delete go from the check state to the finishing
// state; all cells update together in the finishing cycle, with inserts and
// deletes moving each entry from the position on one cell along. Get and
// find send a probe down the cell row one cell per cycle, so the row length
// sets how long they take. A new command is accepted in the cycle after the
// previous result has been loaded into the output register, so the input
// side is free again while a result still waits there.
// When the receiver stalls, the result is held in the output register and a
// finished command waits in its last step until the register frees up.
// The capacity register is written through cfg_wr_en/cfg_wr_data at any
// rising edge and resets to 64. Reset empties the list at once; entry
// storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module ordered_array_list #(
	parameter int DEPTH = oal_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  oal_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output oal_pkg::out_item_t          out_data,
	input  logic                        cfg_wr_en,
	input  logic [oal_pkg::CAP_W-1:0]   cfg_wr_data
);
	import oal_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [CMP_W-1:0] DEPTH_X = CMP_W'(DEPTH);
	localparam logic [CMP_W-1:0] ONE_X   = CMP_W'(1);

	state_t            state_q;
	state_t            state_d;
	in_item_t          req_q;
	logic [CNT_W-1:0]  count_q;
	logic [CAP_W-1:0]  cap_q;
	logic              out_valid_q;
	out_item_t         out_q;
	logic              scan_hit_q;
	logic [DATA_W-1:0] scan_data_q;
	logic [IDX_W-1:0]  scan_idx_q;

	logic              slot_free;
	logic              launch;
	logic              finish;
	logic              scan_cmd;
	logic [CMP_W-1:0]  cnt_x;
	logic [CMP_W-1:0]  pos_x;
	logic [CMP_W-1:0]  cap_x;
	logic [CMP_W-1:0]  cap_eff;
	logic [CMP_W-1:0]  cnt_next;
	logic [CMP_W-1:0]  target;
	status_t           status_d;
	cell_op_t          op_d;
	cell_ctl_t         ctl;
	out_item_t         res_d;

	logic [DATA_W-1:0] cell_data  [DEPTH];
	logic [DATA_W-1:0] left_data  [DEPTH];
	logic [DATA_W-1:0] right_data [DEPTH];
	probe_t            probe      [DEPTH+1];
	logic [IDX_W-1:0]  pidx       [DEPTH+1];

	assign slot_free = !out_valid_q || out_ready;
	assign scan_cmd  = (req_q.command == CMD_GET) || (req_q.command == CMD_FIND);
	assign cnt_x     = CMP_W'(count_q);
	assign pos_x     = CMP_W'(req_q.position);
	assign cap_x     = CMP_W'(cap_q);

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = ONE_X;
		end else if (cap_x > DEPTH_X) begin
			cap_eff = DEPTH_X;
		end else begin
			cap_eff = cap_x;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_valid) begin
					state_d = FSM_CHECK;
				end
			end
			FSM_CHECK: begin
				state_d = scan_cmd ? FSM_SCAN : FSM_FINISH;
			end
			FSM_SCAN: begin
				if (probe[DEPTH].valid) begin
					state_d = FSM_FINISH;
				end
			end
			FSM_FINISH: begin
				if (slot_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		launch   = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			FSM_IDLE:   in_ready = 1'b1;
			FSM_CHECK:  launch   = scan_cmd;
			FSM_SCAN:   ;
			FSM_FINISH: finish   = slot_free;
			default:    ;
		endcase
	end

	always_comb begin
		status_d = ST_OK;
		op_d     = CELL_HOLD;
		cnt_next = cnt_x;
		target   = pos_x;
		res_d    = '0;
		case (req_q.command)
			CMD_APPEND: begin
				target = cnt_x;
				if (cnt_x >= cap_eff) begin
					status_d = ST_FULL;
				end else begin
					op_d     = CELL_LOAD;
					cnt_next = cnt_x + ONE_X;
				end
			end
			CMD_INSERT: begin
				if (cnt_x >= cap_eff) begin
					status_d = ST_FULL;
				end else if (pos_x > cnt_x) begin
					status_d = ST_BADIDX;
				end else begin
					op_d     = CELL_SHIFT_UP;
					cnt_next = cnt_x + ONE_X;
				end
			end
			CMD_EDIT: begin
				if (pos_x >= cnt_x) begin
					status_d = ST_BADIDX;
				end else begin
					op_d = CELL_LOAD;
				end
			end
			CMD_DELETE: begin
				if (cnt_x == '0) begin
					status_d = ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					status_d = ST_BADIDX;
				end else begin
					op_d     = CELL_SHIFT_DN;
					cnt_next = cnt_x - ONE_X;
				end
			end
			CMD_GET: begin
				if (scan_hit_q) begin
					res_d.value_out = scan_data_q;
				end else begin
					status_d = ST_BADIDX;
				end
			end
			CMD_FIND: begin
				if (scan_hit_q) begin
					res_d.found_index = FOUND_W'(scan_idx_q);
				end else begin
					status_d = ST_NOTFOUND;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		res_d.status     = status_d;
		res_d.item_count = cnt_next[ITEM_CNT_W-1:0];
		res_d.full_flag  = (cnt_next >= cap_eff);
		res_d.empty_flag = (cnt_next == '0);
	end

	assign ctl.op   = finish ? op_d : CELL_HOLD;
	assign ctl.find = (req_q.command == CMD_FIND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (finish) begin
				count_q <= cnt_next[CNT_W-1:0];
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data;
		end
		if (finish) begin
			out_q <= res_d;
		end
		if (state_q == FSM_SCAN && probe[DEPTH].valid) begin
			scan_hit_q  <= probe[DEPTH].hit;
			scan_data_q <= probe[DEPTH].data;
			scan_idx_q  <= pidx[DEPTH];
		end
	end

	assign probe[0].valid = launch;
	assign probe[0].hit   = 1'b0;
	assign probe[0].data  = '0;
	assign pidx[0]        = '0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign left_data[g] = cell_data[g];
		end else begin : g_mid_left
			assign left_data[g] = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_data[g] = cell_data[g];
		end else begin : g_mid_right
			assign right_data[g] = cell_data[g+1];
		end

		oal_cell #(
			.CMP_W (CMP_W),
			.IDX_W (IDX_W),
			.IDX   (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.target     (target),
			.count      (cnt_x),
			.value      (req_q.value_in),
			.left_data  (left_data[g]),
			.right_data (right_data[g]),
			.data       (cell_data[g]),
			.probe_in   (probe[g]),
			.pidx_in    (pidx[g]),
			.probe_out  (probe[g+1]),
			.pidx_out   (pidx[g+1])
		);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== sv/oal_checker.sv =====
// ----------------------------------------------------------------------------
// Ordered array list checker
// Port-level properties of the list, attached to the top level by bind.
// ----------------------------------------------------------------------------
module oal_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               out_valid,
	input  logic               out_ready,
	input  oal_pkg::out_item_t out_data
);
	import oal_pkg::*;

	// A stalled result transaction keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Commands are handled one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second command accepted while busy");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.empty_flag == (out_data.item_count == '0)))
		else $error("empty flag does not match the count");

	a_fail_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
			out_data.value_out == '0 && out_data.found_index == '0)
		else $error("failed command returned data");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_FULL |-> out_data.full_flag)
		else $error("full status without full flag");

endmodule

bind ordered_array_list oal_checker u_oal_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== bench/ordered_array_list_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered array list testbench
// Drives list commands through the valid/ready command channel and checks
// every result against a behavioral model of the list kept in the bench.
// Directed cases cover empty and full lists, bad positions, spare command
// codes and out-of-range capacities. Random traffic runs in phases with
// different capacities and fill or drain bias, with random idling on both
// channels and one long receiver stall that backs the block up.
// ----------------------------------------------------------------------------
module ordered_array_list_tb;

	import oal_pkg::*;

	localparam int DEPTH            = DEPTH_DEFAULT;
	localparam int DRAIN_CYCLES     = DEPTH + 4;
	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE  = 125;
	localparam int MAX_REPORTS      = 10;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] VAL_NEG = -32'sd1;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic             in_ready;
	in_item_t         in_data     = '0;
	logic             out_valid;
	logic             out_ready   = 1'b0;
	out_item_t        out_data;
	logic             cfg_wr_en   = 1'b0;
	logic [CAP_W-1:0] cfg_wr_data = '0;

	logic signed [DATA_W-1:0] list_entries [DEPTH];
	int                       list_count   = 0;
	logic [CAP_W-1:0]         capacity_reg = CAP_RESET;
	out_item_t                expected_results [$];

	int error_count       = 0;
	int cycle_count       = 0;
	bit idle_enabled      = 1'b1;
	bit long_hold_request = 1'b0;
	int long_hold_left    = 0;
	int ready_pause_left  = 0;

	ordered_array_list #(
		.DEPTH(DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Applies one command to the list model and returns the result it should produce.
	function automatic out_item_t predict_command(in_item_t cmd);
		out_item_t res;
		int        eff_cap;
		int        pos;
		bit        at_cap;
		res        = '0;
		res.status = ST_OK;
		pos        = int'(cmd.position);
		if (capacity_reg == '0) begin
			eff_cap = 1;
		end else if (int'(capacity_reg) > DEPTH) begin
			eff_cap = DEPTH;
		end else begin
			eff_cap = int'(capacity_reg);
		end
		at_cap = (list_count >= eff_cap);
		case (cmd.command)
			CMD_APPEND: begin
				if (at_cap) begin
					res.status = ST_FULL;
				end else begin
					list_entries[list_count] = cmd.value_in;
					list_count++;
				end
			end
			CMD_INSERT: begin
				if (at_cap) begin
					res.status = ST_FULL;
				end else if (pos > list_count) begin
					res.status = ST_BADIDX;
				end else begin
					for (int i = list_count; i > pos; i--) begin
						list_entries[i] = list_entries[i - 1];
					end
					list_entries[pos] = cmd.value_in;
					list_count++;
				end
			end
			CMD_EDIT: begin
				if (pos >= list_count) begin
					res.status = ST_BADIDX;
				end else begin
					list_entries[pos] = cmd.value_in;
				end
			end
			CMD_DELETE: begin
				if (list_count == 0) begin
					res.status = ST_EMPTY;
				end else if (pos >= list_count) begin
					res.status = ST_BADIDX;
				end else begin
					for (int i = pos; i < list_count - 1; i++) begin
						list_entries[i] = list_entries[i + 1];
					end
					list_count--;
				end
			end
			CMD_GET: begin
				if (pos >= list_count) begin
					res.status = ST_BADIDX;
				end else begin
					res.value_out = list_entries[pos];
				end
			end
			CMD_FIND: begin
				res.status = ST_NOTFOUND;
				for (int i = list_count - 1; i >= 0; i--) begin
					if (list_entries[i] == cmd.value_in) begin
						res.status      = ST_OK;
						res.found_index = FOUND_W'(i);
					end
				end
			end
			default: begin
			end
		endcase
		res.item_count = ITEM_CNT_W'(list_count);
		res.full_flag  = (list_count >= eff_cap);
		res.empty_flag = (list_count == 0);
		return res;
	endfunction

	task automatic report_failure(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	always @(posedge clk) begin
		out_item_t exp_res;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_failure("result transaction with no command outstanding");
				end else begin
					exp_res = expected_results.pop_front();
					if (out_data.status !== exp_res.status ||
					    out_data.value_out !== exp_res.value_out ||
					    out_data.found_index !== exp_res.found_index ||
					    out_data.item_count !== exp_res.item_count ||
					    out_data.full_flag !== exp_res.full_flag ||
					    out_data.empty_flag !== exp_res.empty_flag) begin
						report_failure($sformatf({"mismatch: expected status=%0d value=%0d ",
							"index=%0d count=%0d full=%0b empty=%0b, actual status=%0d ",
							"value=%0d index=%0d count=%0d full=%0b empty=%0b"},
							exp_res.status, exp_res.value_out, exp_res.found_index,
							exp_res.item_count, exp_res.full_flag, exp_res.empty_flag,
							out_data.status, out_data.value_out, out_data.found_index,
							out_data.item_count, out_data.full_flag, out_data.empty_flag));
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_command(in_data));
			end
			if (cfg_wr_en) begin
				capacity_reg = cfg_wr_data;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (long_hold_request) begin
			long_hold_request = 1'b0;
			long_hold_left    = LONG_HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (long_hold_left > 0) begin
			long_hold_left--;
			out_ready <= 1'b0;
		end else if (ready_pause_left > 0) begin
			ready_pause_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (idle_enabled && $urandom_range(0, 3) == 0) begin
				ready_pause_left = gap_length();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ordered_array_list regression: fail");
			$finish;
		end
	end

	// Called on a rising-edge time step; returns on the edge that accepts the transaction.
	task automatic send_command(logic [CMD_W-1:0] code, int pos, logic signed [DATA_W-1:0] val);
		int       gap;
		in_item_t item;
		item.command  = cmd_t'(code);
		item.position = POS_W'(pos);
		item.value_in = val;
		gap = (idle_enabled && $urandom_range(0, 2) == 0) ? gap_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic send_random_item(int grow, int shrink);
		int                       r;
		int                       pos;
		logic [CMD_W-1:0]         code;
		logic signed [DATA_W-1:0] val;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			code = ($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
		end else if (r < 3 + grow) begin
			code = ($urandom_range(0, 1) == 0) ? CMD_APPEND : CMD_INSERT;
		end else if (r < 3 + grow + shrink) begin
			code = CMD_DELETE;
		end else begin
			case ($urandom_range(0, 2))
				0: code = CMD_EDIT;
				1: code = CMD_GET;
				default: code = CMD_FIND;
			endcase
		end
		if ($urandom_range(0, 19) == 0) begin
			pos = $urandom_range(0, 127);
		end else if (code == CMD_INSERT) begin
			pos = $urandom_range(0, list_count);
		end else begin
			pos = $urandom_range(0, (list_count > 0) ? list_count - 1 : 0);
		end
		r = $urandom_range(0, 99);
		if (r < 30 && list_count > 0) begin
			val = list_entries[$urandom_range(0, list_count - 1)];
		end else if (r < 45) begin
			case ($urandom_range(0, 4))
				0: val = VAL_MIN;
				1: val = VAL_MAX;
				2: val = '0;
				3: val = VAL_NEG;
				default: val = $urandom_range(0, 7);
			endcase
		end else begin
			val = $urandom;
		end
		send_command(code, pos, val);
	endtask

	task automatic test_empty_list();
		send_command(CMD_DELETE, 0, '0);
		send_command(CMD_EDIT, 0, VAL_MAX);
		send_command(CMD_GET, 0, '0);
		send_command(CMD_FIND, 0, '0);
		send_command(CMD_INSERT, 1, VAL_MIN);
		send_command(CMD_SPARE_LO, 0, VAL_NEG);
		send_command(CMD_SPARE_HI, 127, VAL_MAX);
	endtask

	task automatic test_capacity_limits();
		write_capacity(7'd0);
		send_command(CMD_APPEND, 0, VAL_MIN);
		send_command(CMD_APPEND, 0, 32'sd5);
		send_command(CMD_INSERT, 0, 32'sd6);
		send_command(CMD_GET, 0, '0);

		write_capacity(7'd4);
		send_command(CMD_INSERT, 1, VAL_MAX);
		send_command(CMD_INSERT, 0, '0);
		send_command(CMD_INSERT, 5, 32'sd9);
		send_command(CMD_APPEND, 0, VAL_NEG);
		send_command(CMD_FIND, 0, VAL_NEG);
		send_command(CMD_EDIT, 4, 32'sd7);
		send_command(CMD_EDIT, 2, 32'sd7);

		write_capacity(7'd2);
		send_command(CMD_APPEND, 0, 32'sd8);
		send_command(CMD_DELETE, 3, '0);
		send_command(CMD_DELETE, 3, '0);
		send_command(CMD_DELETE, 0, '0);
		send_command(CMD_DELETE, 0, '0);
		send_command(CMD_GET, 0, '0);
		send_command(CMD_GET, 127, '0);
		send_command(CMD_FIND, 0, 32'sd99);
	endtask

	task automatic test_backpressure();
		write_capacity(7'd64);
		idle_enabled      = 1'b0;
		long_hold_request = 1'b1;
		repeat (12) send_random_item(60, 10);
		idle_enabled = 1'b1;
		wait_idle();
	endtask

	task automatic test_random_traffic();
		logic [CAP_W-1:0] phase_cap [8];
		int               grow      [8];
		int               shrink    [8];
		phase_cap = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd12, 7'd64, 7'd40, 7'd3};
		grow      = '{55, 55, 10, 30, 55, 10, 30, 55};
		shrink    = '{10, 10, 55, 30, 10, 55, 30, 10};
		phase_cap[6] = $urandom_range(0, 127);
		phase_cap[7] = $urandom_range(0, 127);
		for (int p = 0; p < 8; p++) begin
			write_capacity(phase_cap[p]);
			idle_enabled = (p == 0) || ($urandom_range(0, 3) != 0);
			repeat (ITEMS_PER_PHASE) send_random_item(grow[p], shrink[p]);
		end
		idle_enabled = 1'b1;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_capacity_limits();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("ordered_array_list regression: pass");
		end else begin
			$display("ordered_array_list regression: fail");
		end
		$finish;
	end

endmodule
